// ===== rtl/core/keyed_byte_descrambler_checksum_defines.svh =====
`ifndef KEYED_BYTE_DESCRAMBLER_CHECKSUM_DEFINES_SVH
`define KEYED_BYTE_DESCRAMBLER_CHECKSUM_DEFINES_SVH

// Concurrent check, off while reset is held.
`define KBDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Concurrent check, live during reset too.
`define KBDC_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/kbdc_pkg.sv =====
package kbdc_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NAME_KEY_LOW  = 3'd0,
    REG_NAME_KEY_HIGH = 3'd1,
    REG_EXPECTED_SUM  = 3'd2,
    REG_EXPECTED_XOR  = 3'd3,
    REG_SECOND_PASS   = 3'd4
  } cfg_reg_e;

  localparam logic [31:0] XOR_SEED = 32'd56879;
  localparam logic [3:0]  MOD15_LAST = 4'd14;

  localparam logic [8*15-1:0] KEY15_STR = "GURUguruMinmIN_";
  localparam logic [8*64-1:0] KEY64_STR =
    "!~_Q#xDRgd-d&yfg&'(8)(5(594er2f4asf5f6e5f4s5fvwyjk%fgqTUCFD4568r";

  typedef struct packed {
    logic [31:0] name_key_low;
    logic [31:0] name_key_high;
    logic [31:0] expected_sum;
    logic [31:0] expected_xor;
    logic        second_pass;
  } cfg_t;

  typedef struct packed {
    logic [7:0] idx_low;
    logic [3:0] idx_mod15;
  } pos_t;

  function automatic logic [7:0] key15_at(input logic [3:0] m);
    logic [3:0] mm;
    mm = (m > MOD15_LAST) ? 4'd0 : m;
    return KEY15_STR[8*(14 - int'(mm)) +: 8];
  endfunction

  function automatic logic [7:0] key64_at(input logic [5:0] pos, input logic [31:0] lo,
                                          input logic [31:0] hi);
    logic [31:0] word;
    word = pos[2] ? hi : lo;
    if (pos[5:3] == 3'd1) begin
      return word[8*int'(pos[1:0]) +: 8];
    end
    return KEY64_STR[8*(63 - int'(pos)) +: 8];
  endfunction

endpackage

// ===== rtl/core/kbdc_cfg.sv =====
module kbdc_cfg import kbdc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_NAME_KEY_LOW:  cfg_d.name_key_low  = cfg_data_i;
        REG_NAME_KEY_HIGH: cfg_d.name_key_high = cfg_data_i;
        REG_EXPECTED_SUM:  cfg_d.expected_sum  = cfg_data_i;
        REG_EXPECTED_XOR:  cfg_d.expected_xor  = cfg_data_i;
        REG_SECOND_PASS:   cfg_d.second_pass   = cfg_data_i[0];
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.name_key_low  <= '0;
      cfg_q.name_key_high <= '0;
      cfg_q.expected_sum  <= '0;
      cfg_q.expected_xor  <= XOR_SEED;
      cfg_q.second_pass   <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/kbdc_descr.sv =====
module kbdc_descr import kbdc_pkg::*; (
  input  cfg_t       cfg_i,
  input  pos_t       pos_i,
  input  logic [7:0] cipher_i,
  output logic [7:0] plain_o,
  output logic [7:0] out_byte_o
);

  logic [7:0]  k64;
  logic [7:0]  mult;
  logic [15:0] prod;
  logic [7:0]  swap_src;

  always_comb begin
    k64      = key64_at(pos_i.idx_low[5:0], cfg_i.name_key_low, cfg_i.name_key_high);
    mult     = key15_at(pos_i.idx_mod15) + {5'd0, pos_i.idx_low[2:0]};
    prod     = k64 * mult;
    plain_o  = ~cipher_i ^ prod[7:0];
    swap_src = ~(plain_o ^ pos_i.idx_low);
    out_byte_o = cfg_i.second_pass ? {swap_src[3:0], swap_src[7:4]} : plain_o;
  end

endmodule

// ===== rtl/core/kbdc_accum.sv =====
module kbdc_accum import kbdc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       advance_i,
  input  logic       last_i,
  input  logic [7:0] plain_i,
  output pos_t       pos_o,
  output logic       sum_match_o,
  output logic       xor_match_o
);

  pos_t        pos_q, pos_d;
  logic [31:0] sum_q, sum_d;
  logic [31:0] xor_q, xor_d;
  logic [31:0] sum_next;
  logic [31:0] xor_next;

  always_comb begin
    sum_next = sum_q + {24'd0, plain_i};
    xor_next = xor_q ^ {24'd0, plain_i};
    sum_match_o = last_i && (sum_next == cfg_i.expected_sum);
    xor_match_o = last_i && (xor_next == cfg_i.expected_xor);

    pos_d = pos_q;
    sum_d = sum_q;
    xor_d = xor_q;
    if (advance_i) begin
      if (last_i) begin
        pos_d = '0;
        sum_d = '0;
        xor_d = XOR_SEED;
      end else begin
        pos_d.idx_low   = pos_q.idx_low + 8'd1;
        pos_d.idx_mod15 = (pos_q.idx_mod15 >= MOD15_LAST) ? 4'd0 : pos_q.idx_mod15 + 4'd1;
        sum_d = sum_next;
        xor_d = xor_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      sum_q <= '0;
      xor_q <= XOR_SEED;
    end else begin
      pos_q <= pos_d;
      sum_q <= sum_d;
      xor_q <= xor_d;
    end
  end

  assign pos_o = pos_q;

endmodule

// ===== rtl/core/keyed_byte_descrambler_checksum.sv =====
// Keyed byte descrambler with running checksums. Takes one scrambled byte per beat on the
// slave stream and returns one plain byte per beat on the master stream, at a sustained rate
// of one byte per clock unless m_axis_tready stalls the output: an input register holds
// the beat, the key lookup, 8x8 multiply and checksum update sit between it and the result
// register. Configuration registers (name keys, expected sum and xor, second pass) must be
// written through the cfg port between runs; the block does not enforce this. On the tlast
// beat, tuser has the sum/xor match flags; position counters and checksums return to start.
module keyed_byte_descrambler_checksum import kbdc_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] cipher_byte
  input  logic                s_axis_tlast,   // final_byte
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,   // [7:0] plain_byte
  output logic                m_axis_tlast,   // end_of_run
  output logic [1:0]          m_axis_tuser    // [0] sum_match, [1] xor_match
);

  cfg_t       cfg;
  pos_t       pos;
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       out_last_q;
  logic [1:0] out_flags_q;
  logic       advance;
  logic       s_accept;
  logic [7:0] plain;
  logic [7:0] out_byte;
  logic       sum_match;
  logic       xor_match;

  kbdc_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  kbdc_descr u_descr (
    .cfg_i      (cfg),
    .pos_i      (pos),
    .cipher_i   (in_byte_q),
    .plain_o    (plain),
    .out_byte_o (out_byte)
  );

  kbdc_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .advance_i   (advance),
    .last_i      (in_last_q),
    .plain_i     (plain),
    .pos_o       (pos),
    .sum_match_o (sum_match),
    .xor_match_o (xor_match)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_byte_q <= s_axis_tdata;
      in_last_q <= s_axis_tlast;
    end
    if (advance) begin
      out_byte_q  <= out_byte;
      out_last_q  <= in_last_q;
      out_flags_q <= {xor_match, sum_match};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_flags_q;

endmodule

// ===== rtl/core/kbdc_checker.sv =====
`include "keyed_byte_descrambler_checksum_defines.svh"

module kbdc_checker import kbdc_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cfg_we_i,
  input logic [CfgIdxW-1:0]  cfg_index_i,
  input logic [CfgDataW-1:0] cfg_data_i,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic [7:0]          s_axis_tdata,
  input logic                s_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [7:0]          m_axis_tdata,
  input logic                m_axis_tlast,
  input logic [1:0]          m_axis_tuser
);

  logic [1:0] pending_q;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_beat && !out_beat) begin
      pending_q <= pending_q + 2'd1;
    end else if (out_beat && !in_beat) begin
      pending_q <= pending_q - 2'd1;
    end
  end

  `KBDC_ASSERT(a_flags_only_on_last, m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == 2'b00, "match flag outside last beat")
  `KBDC_ASSERT(a_stall_holds, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled beat changed")
  `KBDC_ASSERT(a_pending_bound, pending_q <= 2'd2 && (pending_q != 2'd0 || !m_axis_tvalid), "beat count mismatch between streams")
  `KBDC_ASSERT_RST(a_reset_quiet, !rst_ni |=> !m_axis_tvalid, "output valid right after reset")

endmodule

bind keyed_byte_descrambler_checksum kbdc_checker u_kbdc_checker (.*);
